>>> hdl/sprint_start_false_start_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Sprint start sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk with reset arst_n.
// ----------------------------------------------------------------------------
`ifndef SPRINT_START_FALSE_START_SEQUENCER_MACROS_SVH
`define SPRINT_START_FALSE_START_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define SSSQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SSSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/sssq_pkg.sv
// ----------------------------------------------------------------------------
// Sprint start sequencer package
// Types, widths, register codes and reset values shared by the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sssq_pkg;

	localparam int unsigned TICK_MS = 5;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_GET_READY     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BASE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_REACTION  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_OK    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_FALSE = 3'd4;

	localparam int unsigned GRT_RAW = 3000 / TICK_MS;
	localparam int unsigned SBT_RAW = 1500 / TICK_MS;
	localparam int unsigned MRT_RAW = 100 / TICK_MS;
	localparam int unsigned HOK_RAW = 3000 / TICK_MS;
	localparam int unsigned HFS_RAW = 1000 / TICK_MS;

	localparam logic [9:0] GET_READY_RST     = (GRT_RAW > 1023) ? 10'd1023 : 10'(GRT_RAW);
	localparam logic [8:0] SET_BASE_RST      = (SBT_RAW > 511) ? 9'd511 : 9'(SBT_RAW);
	localparam logic [7:0] MIN_REACTION_RST  = (MRT_RAW > 255) ? 8'd255 : 8'(MRT_RAW);
	localparam logic [9:0] HOLDOFF_OK_RST    = (HOK_RAW > 1023) ? 10'd1023 : 10'(HOK_RAW);
	localparam logic [9:0] HOLDOFF_FALSE_RST = (HFS_RAW > 1023) ? 10'd1023 : 10'(HFS_RAW);

	localparam logic [8:0]  SET_TARGET_MAX = 9'h1FF;
	localparam logic [15:0] REACTION_MAX   = 16'hFFFF;

	typedef struct packed {
		logic [9:0] get_ready_ticks;
		logic [8:0] set_base_ticks;
		logic [7:0] min_reaction_ticks;
		logic [9:0] holdoff_ok_ticks;
		logic [9:0] holdoff_false_ticks;
	} cfg_t;

	typedef struct packed {
		logic       base_load;
		logic [8:0] base_val;
	} cfg_evt_t;

	typedef struct packed {
		logic       plate_pressed;
		logic       switch_on;
		logic [7:0] random_ticks;
	} item_t;

	typedef struct packed {
		logic        set_cue;
		logic        gun_fire;
		logic        valid_start;
		logic        false_start_flag;
		logic [15:0] reaction_ticks;
		logic        busy_res;
	} res_t;

endpackage

>>> hdl/sssq_if.sv
// ----------------------------------------------------------------------------
// Sprint start sequencer channel interfaces
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sssq_item_if;
	logic       valid;
	logic       ready;
	logic       plate_pressed;
	logic       switch_on;
	logic [7:0] random_ticks;

	modport source (output valid, output plate_pressed, output switch_on,
		output random_ticks, input ready);
	modport sink (input valid, input plate_pressed, input switch_on,
		input random_ticks, output ready);
endinterface

interface sssq_res_if;
	logic        valid;
	logic        ready;
	logic        set_cue;
	logic        gun_fire;
	logic        valid_start;
	logic        false_start_flag;
	logic [15:0] reaction_ticks;
	logic        busy_res;

	modport source (output valid, output set_cue, output gun_fire, output valid_start,
		output false_start_flag, output reaction_ticks, output busy_res, input ready);
	modport sink (input valid, input set_cue, input gun_fire, input valid_start,
		input false_start_flag, input reaction_ticks, input busy_res, output ready);
endinterface

>>> hdl/sssq_cfg.sv
// ----------------------------------------------------------------------------
// Sprint start sequencer configuration registers
// Holds the five timing registers and flags a write of the set base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sssq_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [sssq_pkg::CFG_IDX_W-1:0]   wr_idx,
	input  logic [sssq_pkg::CFG_DATA_W-1:0]  wr_data,
	output sssq_pkg::cfg_t                   cfg,
	output sssq_pkg::cfg_evt_t               evt
);

	sssq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.get_ready_ticks     <= sssq_pkg::GET_READY_RST;
			cfg_q.set_base_ticks      <= sssq_pkg::SET_BASE_RST;
			cfg_q.min_reaction_ticks  <= sssq_pkg::MIN_REACTION_RST;
			cfg_q.holdoff_ok_ticks    <= sssq_pkg::HOLDOFF_OK_RST;
			cfg_q.holdoff_false_ticks <= sssq_pkg::HOLDOFF_FALSE_RST;
		end else if (wr_en) begin
			unique case (wr_idx)
				sssq_pkg::CFG_GET_READY:     cfg_q.get_ready_ticks     <= wr_data;
				sssq_pkg::CFG_SET_BASE:      cfg_q.set_base_ticks      <= wr_data[8:0];
				sssq_pkg::CFG_MIN_REACTION:  cfg_q.min_reaction_ticks  <= wr_data[7:0];
				sssq_pkg::CFG_HOLDOFF_OK:    cfg_q.holdoff_ok_ticks    <= wr_data;
				sssq_pkg::CFG_HOLDOFF_FALSE: cfg_q.holdoff_false_ticks <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg           = cfg_q;
	assign evt.base_load = wr_en && (wr_idx == sssq_pkg::CFG_SET_BASE);
	assign evt.base_val  = wr_data[8:0];

endmodule

>>> hdl/sssq_core.sv
// ----------------------------------------------------------------------------
// Sprint start sequencer core
// Input register, sequence state and the per-tick update logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sprint_start_false_start_sequencer_macros.svh"

module sssq_core (
	input  logic               clk,
	input  logic               arst_n,
	sssq_item_if.sink          item_in,
	input  sssq_pkg::cfg_t     cfg,
	input  sssq_pkg::cfg_evt_t evt,
	output logic               res_valid,
	output sssq_pkg::res_t     res,
	input  logic               res_ready
);

	logic            valid_s1;
	sssq_pkg::item_t item_s1;
	logic            adv;
	logic            take;

	logic        athlete_ready_q, start_requested_q, gun_done_q, set_cue_done_q;
	logic [9:0]  ready_count_q;
	logic [8:0]  set_count_q;
	logic [8:0]  set_target_q;
	logic [15:0] reaction_count_q;
	logic [9:0]  holdoff_count_q;

	logic        ar_d, sr_d, gd_d, scd_d;
	logic [9:0]  rdy_d;
	logic [8:0]  sc_d;
	logic [8:0]  tgt_d;
	logic [15:0] rc_d;
	logic [9:0]  ho_d;
	logic [9:0]  tgt_sum;
	sssq_pkg::res_t res_d;

	assign adv          = valid_s1 && res_ready;
	assign item_in.ready = !valid_s1 || res_ready;
	assign take         = item_in.valid && item_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.plate_pressed <= item_in.plate_pressed;
			item_s1.switch_on     <= item_in.switch_on;
			item_s1.random_ticks  <= item_in.random_ticks;
		end
	end

	assign tgt_sum = {1'b0, cfg.set_base_ticks} + {2'b00, item_s1.random_ticks};

	always_comb begin
		ar_d  = athlete_ready_q;
		sr_d  = start_requested_q;
		gd_d  = gun_done_q;
		scd_d = set_cue_done_q;
		rdy_d = ready_count_q;
		sc_d  = set_count_q;
		tgt_d = set_target_q;
		rc_d  = reaction_count_q;
		ho_d  = holdoff_count_q;
		res_d = '0;
		if (holdoff_count_q != 10'd0) begin
			ho_d         = holdoff_count_q - 10'd1;
			res_d.busy_res = 1'b1;
		end else begin
			if (gun_done_q && (reaction_count_q != sssq_pkg::REACTION_MAX)) begin
				rc_d = reaction_count_q + 16'd1;
			end
			if (item_s1.plate_pressed) begin
				ar_d = 1'b1;
				if (item_s1.switch_on) begin
					sr_d = 1'b1;
				end
			end
			if (ar_d && sr_d) begin
				if (ready_count_q < cfg.get_ready_ticks) begin
					rdy_d = ready_count_q + 10'd1;
				end else begin
					if (!set_cue_done_q) begin
						scd_d         = 1'b1;
						res_d.set_cue = 1'b1;
					end
					if (set_count_q < set_target_q) begin
						sc_d = set_count_q + 9'd1;
					end else begin
						res_d.gun_fire = 1'b1;
						rc_d           = 16'd0;
						gd_d           = 1'b1;
						sr_d           = 1'b0;
					end
				end
			end
			if (ar_d && !item_s1.plate_pressed) begin
				if (gd_d && (rc_d >= {8'd0, cfg.min_reaction_ticks})) begin
					res_d.valid_start    = 1'b1;
					res_d.reaction_ticks = rc_d;
					ho_d                 = cfg.holdoff_ok_ticks;
				end else begin
					res_d.false_start_flag = 1'b1;
					ho_d                   = cfg.holdoff_false_ticks;
				end
				tgt_d = tgt_sum[9] ? sssq_pkg::SET_TARGET_MAX : tgt_sum[8:0];
				rdy_d = 10'd0;
				sc_d  = 9'd0;
				scd_d = 1'b0;
				sr_d  = 1'b0;
				ar_d  = 1'b0;
				gd_d  = 1'b0;
				rc_d  = 16'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			athlete_ready_q   <= 1'b0;
			start_requested_q <= 1'b0;
			gun_done_q        <= 1'b0;
			set_cue_done_q    <= 1'b0;
			ready_count_q     <= '0;
			set_count_q       <= '0;
			set_target_q      <= sssq_pkg::SET_BASE_RST;
			reaction_count_q  <= '0;
			holdoff_count_q   <= '0;
		end else if (evt.base_load) begin
			set_target_q <= evt.base_val;
		end else if (adv) begin
			athlete_ready_q   <= ar_d;
			start_requested_q <= sr_d;
			gun_done_q        <= gd_d;
			set_cue_done_q    <= scd_d;
			ready_count_q     <= rdy_d;
			set_count_q       <= sc_d;
			set_target_q      <= tgt_d;
			reaction_count_q  <= rc_d;
			holdoff_count_q   <= ho_d;
		end
	end

	assign res_valid = valid_s1;
	assign res       = res_d;

	`SSSQ_ASSERT_NOW(a_holdoff_only_busy, adv && (holdoff_count_q != 10'd0), res_d.busy_res && !res_d.set_cue && !res_d.gun_fire && !res_d.valid_start && !res_d.false_start_flag, "hold-off tick gave more than busy")
	`SSSQ_ASSERT_NOW(a_one_verdict, adv, !(res_d.valid_start && res_d.false_start_flag), "valid and false start on one tick")
	`SSSQ_ASSERT_NEXT(a_gun_arms, adv && res_d.gun_fire && !res_d.valid_start && !res_d.false_start_flag && !evt.base_load, gun_done_q && (reaction_count_q == 16'd0), "gun did not start reaction count")
	`SSSQ_ASSERT_NEXT(a_verdict_clears, adv && (res_d.valid_start || res_d.false_start_flag), !athlete_ready_q && !gun_done_q && !start_requested_q, "sequence not cleared after start verdict")

endmodule

>>> hdl/sssq_obuf.sv
// ----------------------------------------------------------------------------
// Sprint start sequencer result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sssq_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_valid,
	input  sssq_pkg::res_t res,
	output logic           res_ready,
	sssq_res_if.source     res_out
);

	logic           valid_q;
	sssq_pkg::res_t data_q;

	assign res_ready = !valid_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

	assign res_out.valid            = valid_q;
	assign res_out.set_cue          = data_q.set_cue;
	assign res_out.gun_fire         = data_q.gun_fire;
	assign res_out.valid_start      = data_q.valid_start;
	assign res_out.false_start_flag = data_q.false_start_flag;
	assign res_out.reaction_ticks   = data_q.reaction_ticks;
	assign res_out.busy_res         = data_q.busy_res;

endmodule

>>> hdl/sprint_start_false_start_sequencer.sv
// ----------------------------------------------------------------------------
// Sprint start false-start sequencer
// Block plate and start switch sequencing with set cue, gun and start verdict.
// ----------------------------------------------------------------------------
// The block takes one tick item per clock cycle while the output side keeps
// up, and returns exactly one result item for each, in order. A tick goes into
// an input register, the sequence state and the result are computed from it in
// the following cycle, and the result waits in an output register before it
// leaves. Each register advances when it is empty or the stage after it takes
// its item, so the output side's ready holds back both. There is no clearing
// pass after reset; timing registers may be written at any time the block
// holds no tick.
`timescale 1ns / 1ps

module sprint_start_false_start_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	sssq_item_if.sink                       item_in,
	sssq_res_if.source                      res_out,
	input  logic                            wr_en,
	input  logic [sssq_pkg::CFG_IDX_W-1:0]  wr_idx,
	input  logic [sssq_pkg::CFG_DATA_W-1:0] wr_data
);

	sssq_pkg::cfg_t     cfg;
	sssq_pkg::cfg_evt_t evt;
	sssq_pkg::res_t     res;
	logic               res_valid;
	logic               res_ready;

	sssq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.cfg     (cfg),
		.evt     (evt)
	);

	sssq_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_in),
		.cfg       (cfg),
		.evt       (evt),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	sssq_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.res_out   (res_out)
	);

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Sprint start sequencer testbench
// Drives tick items through the valid/ready input channel and checks each
// result item field by field against an in-bench model of the start sequence,
// covering directed sequences, counter extremes and random races under several
// settings of the timing registers and of the idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned IDX_W = sssq_pkg::CFG_IDX_W;
	localparam int unsigned DATA_W = sssq_pkg::CFG_DATA_W;

	logic              clk;
	logic              arst_n;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [DATA_W-1:0] wr_data;

	sssq_item_if tick_ch ();
	sssq_res_if  res_ch ();

	sprint_start_false_start_sequencer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_in (tick_ch),
		.res_out (res_ch),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	int unsigned cycle_count = 0;
	int unsigned errors = 0;
	int unsigned results_seen = 0;
	int unsigned live_items = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	sssq_pkg::res_t expected_results[$];

	sssq_pkg::cfg_t timing;
	logic        athlete_on;
	logic        start_req;
	logic        gun_live;
	logic        cue_given;
	logic [9:0]  ready_cnt;
	logic [8:0]  set_cnt;
	logic [8:0]  set_tgt;
	logic [15:0] react_cnt;
	logic [9:0]  holdoff_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic sssq_pkg::res_t step_sequence(input sssq_pkg::item_t t);
		sssq_pkg::res_t r;
		logic [9:0]     sum;
		r = '0;
		if (holdoff_cnt != 0) begin
			holdoff_cnt--;
			r.busy_res = 1'b1;
			return r;
		end
		if (gun_live && react_cnt != sssq_pkg::REACTION_MAX)
			react_cnt++;
		if (t.plate_pressed) begin
			athlete_on = 1'b1;
			if (t.switch_on)
				start_req = 1'b1;
		end
		if (athlete_on && start_req) begin
			if (ready_cnt < timing.get_ready_ticks) begin
				ready_cnt++;
			end else begin
				if (!cue_given) begin
					cue_given = 1'b1;
					r.set_cue = 1'b1;
				end
				if (set_cnt < set_tgt) begin
					set_cnt++;
				end else begin
					r.gun_fire = 1'b1;
					react_cnt = '0;
					gun_live = 1'b1;
					start_req = 1'b0;
				end
			end
		end
		if (athlete_on && !t.plate_pressed) begin
			if (gun_live && react_cnt >= 16'(timing.min_reaction_ticks)) begin
				r.valid_start = 1'b1;
				r.reaction_ticks = react_cnt;
				holdoff_cnt = timing.holdoff_ok_ticks;
			end else begin
				r.false_start_flag = 1'b1;
				holdoff_cnt = timing.holdoff_false_ticks;
			end
			sum = 10'(timing.set_base_ticks) + 10'(t.random_ticks);
			set_tgt = (sum > 10'(sssq_pkg::SET_TARGET_MAX)) ? sssq_pkg::SET_TARGET_MAX
				: sum[8:0];
			ready_cnt = '0;
			set_cnt = '0;
			cue_given = 1'b0;
			start_req = 1'b0;
			athlete_on = 1'b0;
			gun_live = 1'b0;
			react_cnt = '0;
		end
		return r;
	endfunction

	task automatic report_error(input string msg);
		errors++;
		if (errors <= 50)
			$display("ERROR at cycle %0d: %s", cycle_count, msg);
	endtask

	// Called at a rising edge; returns at the edge where the item is taken.
	task automatic send_tick(input logic plate, input logic sw, input logic [7:0] rnd);
		sssq_pkg::item_t t;
		sssq_pkg::res_t  r;
		while ($urandom_range(99) < send_idle_pct) begin
			tick_ch.valid <= 1'b0;
			tick_ch.plate_pressed <= 1'($urandom);
			tick_ch.switch_on <= 1'($urandom);
			tick_ch.random_ticks <= 8'($urandom);
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.plate_pressed <= plate;
		tick_ch.switch_on <= sw;
		tick_ch.random_ticks <= rnd;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		t.plate_pressed = plate;
		t.switch_on = sw;
		t.random_ticks = rnd;
		r = step_sequence(t);
		expected_results.push_back(r);
		if (!r.busy_res)
			live_items++;
	endtask

	task automatic send_noise();
		send_tick(1'($urandom), 1'($urandom), 8'($urandom));
	endtask

	task automatic wait_drained();
		tick_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= data;
		@(posedge clk);
		case (idx)
			sssq_pkg::CFG_GET_READY:     timing.get_ready_ticks = data;
			sssq_pkg::CFG_SET_BASE: begin
				timing.set_base_ticks = data[8:0];
				set_tgt = data[8:0];
			end
			sssq_pkg::CFG_MIN_REACTION:  timing.min_reaction_ticks = data[7:0];
			sssq_pkg::CFG_HOLDOFF_OK:    timing.holdoff_ok_ticks = data;
			sssq_pkg::CFG_HOLDOFF_FALSE: timing.holdoff_false_ticks = data;
			default: ;
		endcase
	endtask

	task automatic load_timing(input logic [9:0] gr, input logic [9:0] sb, input logic [9:0] mr,
		input logic [9:0] hok, input logic [9:0] hfs);
		wait_drained();
		cfg_write(sssq_pkg::CFG_GET_READY, gr);
		cfg_write(sssq_pkg::CFG_SET_BASE, sb);
		cfg_write(sssq_pkg::CFG_MIN_REACTION, mr);
		cfg_write(sssq_pkg::CFG_HOLDOFF_OK, hok);
		cfg_write(sssq_pkg::CFG_HOLDOFF_FALSE, hfs);
		for (int i = int'(sssq_pkg::CFG_HOLDOFF_FALSE) + 1; i < (1 << IDX_W); i++)
			cfg_write(IDX_W'(i), DATA_W'($urandom));
		wr_en <= 1'b0;
	endtask

	task automatic wait_holdoff();
		while (holdoff_cnt != 0)
			send_noise();
	endtask

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready)
				check_result();
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic check_result();
		sssq_pkg::res_t got;
		sssq_pkg::res_t want;
		got.set_cue = res_ch.set_cue;
		got.gun_fire = res_ch.gun_fire;
		got.valid_start = res_ch.valid_start;
		got.false_start_flag = res_ch.false_start_flag;
		got.reaction_ticks = res_ch.reaction_ticks;
		got.busy_res = res_ch.busy_res;
		results_seen++;
		if (expected_results.size() == 0) begin
			report_error($sformatf("result %0d arrived with none expected", results_seen));
			return;
		end
		want = expected_results.pop_front();
		if (got.set_cue !== want.set_cue)
			report_error($sformatf("result %0d set_cue %b, expected %b",
				results_seen, got.set_cue, want.set_cue));
		if (got.gun_fire !== want.gun_fire)
			report_error($sformatf("result %0d gun_fire %b, expected %b",
				results_seen, got.gun_fire, want.gun_fire));
		if (got.valid_start !== want.valid_start)
			report_error($sformatf("result %0d valid_start %b, expected %b",
				results_seen, got.valid_start, want.valid_start));
		if (got.false_start_flag !== want.false_start_flag)
			report_error($sformatf("result %0d false_start_flag %b, expected %b",
				results_seen, got.false_start_flag, want.false_start_flag));
		if (got.reaction_ticks !== want.reaction_ticks)
			report_error($sformatf("result %0d reaction_ticks %0d, expected %0d",
				results_seen, got.reaction_ticks, want.reaction_ticks));
		if (got.busy_res !== want.busy_res)
			report_error($sformatf("result %0d busy_res %b, expected %b",
				results_seen, got.busy_res, want.busy_res));
	endtask

	task automatic test_sequence();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		load_timing(10'd1, 10'd1, 10'd1, 10'd2, 10'd1);
		send_tick(1'b0, 1'b1, 8'h00);
		send_tick(1'b1, 1'b0, 8'hFF);
		send_tick(1'b1, 1'b1, 8'h00);
		send_tick(1'b1, 1'b1, 8'h00);
		send_tick(1'b1, 1'b1, 8'h00);
		send_tick(1'b1, 1'b1, 8'h00);
		send_tick(1'b0, 1'b1, 8'hFF);
		send_tick(1'b1, 1'b1, 8'h55);
		send_tick(1'b0, 1'b0, 8'hAA);
		send_tick(1'b1, 1'b1, 8'h00);
		send_tick(1'b0, 1'b0, 8'h80);
		send_tick(1'b1, 1'b1, 8'h7F);
	endtask

	task automatic test_zero_counts();
		load_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
		send_tick(1'b1, 1'b1, 8'h00);
		send_tick(1'b1, 1'b0, 8'h00);
		send_tick(1'b0, 1'b0, 8'h01);
		load_timing(10'd1, 10'd0, 10'd0, 10'd0, 10'd0);
		send_tick(1'b1, 1'b1, 8'h00);
		send_tick(1'b0, 1'b0, 8'h00);
		load_timing(10'd1, 10'd0, 10'd1, 10'd0, 10'd0);
		send_tick(1'b1, 1'b1, 8'h00);
		send_tick(1'b0, 1'b0, 8'h00);
	endtask

	task automatic test_extremes();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		load_timing(10'd0, 10'd400, 10'h3FF, 10'd0, 10'd0);
		send_tick(1'b1, 1'b1, 8'h00);
		send_tick(1'b0, 1'b0, 8'hFF);
		send_tick(1'b1, 1'b1, 8'h00);
		while (!gun_live)
			send_tick(1'b1, 1'b0, 8'($urandom));
		send_tick(1'b0, 1'b0, 8'($urandom));
		wait_holdoff();
	endtask

	task automatic run_race();
		int unsigned arm_n;
		int unsigned run_n;
		int unsigned sw_n;
		logic [7:0]  rnd;
		if ($urandom_range(99) < 30)
			send_tick(1'b0, 1'($urandom), 8'($urandom));
		arm_n = $urandom_range(0, 3);
		for (int i = 0; i < arm_n; i++)
			send_tick(1'b1, 1'b0, 8'($urandom));
		run_n = $urandom_range(0, timing.get_ready_ticks + set_tgt
			+ timing.min_reaction_ticks + 6);
		sw_n = $urandom_range(1, run_n + 1);
		for (int i = 0; i < run_n; i++) begin
			if ($urandom_range(99) < 4)
				send_noise();
			else
				send_tick(1'b1, (i < sw_n) ? 1'b1 : 1'($urandom), 8'($urandom));
		end
		rnd = ($urandom_range(99) < 10) ? 8'($urandom) : 8'($urandom_range(0, 7));
		send_tick(1'b0, 1'($urandom), rnd);
		wait_holdoff();
	endtask

	task automatic test_random_races();
		int unsigned goal;
		for (int phase = 0; phase < 8; phase++) begin
			load_timing(10'($urandom_range(0, 12)), 10'($urandom_range(0, 10)),
				10'($urandom_range(0, 8)), 10'($urandom_range(0, 6)),
				10'($urandom_range(0, 6)));
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 87;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 87;
				end
				default: begin
					send_idle_pct = 26;
					recv_stall_pct = 26;
				end
			endcase
			goal = live_items + 70;
			while (live_items < goal)
				run_race();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_idx = '0;
		wr_data = '0;
		tick_ch.valid = 1'b0;
		tick_ch.plate_pressed = 1'b0;
		tick_ch.switch_on = 1'b0;
		tick_ch.random_ticks = '0;
		timing.get_ready_ticks = sssq_pkg::GET_READY_RST;
		timing.set_base_ticks = sssq_pkg::SET_BASE_RST;
		timing.min_reaction_ticks = sssq_pkg::MIN_REACTION_RST;
		timing.holdoff_ok_ticks = sssq_pkg::HOLDOFF_OK_RST;
		timing.holdoff_false_ticks = sssq_pkg::HOLDOFF_FALSE_RST;
		athlete_on = 1'b0;
		start_req = 1'b0;
		gun_live = 1'b0;
		cue_given = 1'b0;
		ready_cnt = '0;
		set_cnt = '0;
		set_tgt = sssq_pkg::SET_BASE_RST;
		react_cnt = '0;
		holdoff_cnt = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sequence();
		test_zero_counts();
		test_extremes();
		test_random_races();

		wait_drained();
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_results.size()));
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
